// ===== hdl/ewq_pkg.sv =====
// shared types and constants for the event wait queue manager
`default_nettype none
package ewq_pkg;

  localparam int unsigned NUM_EVENTS_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH_DEF  = 8;
  localparam int unsigned TASK_ID_BITS_DEF = 8;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned EVENT_W  = 4;
  localparam int unsigned TASK_W   = 8;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_WAIT     = 2'd0,
    KIND_WAKE_ONE = 2'd1,
    KIND_WAKE_ALL = 2'd2,
    KIND_RSVD     = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_SUSPENDED = 2'd0,
    ST_FULL      = 2'd1,
    ST_WOKEN     = 2'd2,
    ST_NONE      = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic post_wait;
    logic post_full;
    logic post_none;
    logic start_wake;
    logic emit_pop;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_wait;
    logic room;
    logic none;
    logic finish;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/event_wait_queue_manager_top.sv =====
// top level of the event wait queue manager
// Keeps a FIFO wait queue of task ids per event number. One item is worked on at a
// time: a lookup state answers a wait, a wake of an empty queue or an unknown kind,
// or starts a wake; a drain state then gives one woken task per cycle while the
// result side does not stall, one task for a wake-one and every waiter for a wake-all.
// Reads of the queue metadata memory and the waiter memory are registered. Queue state is
// empty right after reset through per-event valid bits, with no clearing pass.
`default_nettype none
module event_wait_queue_manager_top #(
  parameter int unsigned NUM_EVENTS   = ewq_pkg::NUM_EVENTS_DEF,
  parameter int unsigned QUEUE_DEPTH  = ewq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TASK_ID_BITS = ewq_pkg::TASK_ID_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [ewq_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [ewq_pkg::EVENT_W-1:0]  event_id_i,
  input  wire logic [ewq_pkg::TASK_W-1:0]   task_id_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [ewq_pkg::STATUS_W-1:0]      status_o,
  output logic [ewq_pkg::TASK_W-1:0]        woken_task_o,
  output logic                              last_o
);
  import ewq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  ewq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ewq_datapath #(
    .NUM_EVENTS   (NUM_EVENTS),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (kind_i),
    .event_id_i   (event_id_i),
    .task_id_i    (task_id_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .woken_task_o (woken_task_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire

// ===== hdl/ewq_ctrl.sv =====
// controller state machine for the event wait queue manager
`default_nettype none
module ewq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  ewq_pkg::dp_status_t     stat_i,
  output ewq_pkg::dp_cmd_t        cmd_o
);
  import ewq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_DRAIN  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (stat_i.is_wait) begin
          if (stat_i.out_free) begin
            cmd_o.post_wait = stat_i.room;
            cmd_o.post_full = !stat_i.room;
            state_d         = S_IDLE;
          end
        end else if (stat_i.none) begin
          if (stat_i.out_free) begin
            cmd_o.post_none = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          cmd_o.start_wake = 1'b1;
          state_d          = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat_i.out_free) begin
          cmd_o.emit_pop = 1'b1;
          if (stat_i.finish) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ewq_datapath.sv =====
// queue metadata, waiter memory and result register
`default_nettype none
module ewq_datapath #(
  parameter int unsigned NUM_EVENTS   = ewq_pkg::NUM_EVENTS_DEF,
  parameter int unsigned QUEUE_DEPTH  = ewq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TASK_ID_BITS = ewq_pkg::TASK_ID_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [ewq_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [ewq_pkg::EVENT_W-1:0]  event_id_i,
  input  wire logic [ewq_pkg::TASK_W-1:0]   task_id_i,
  input  ewq_pkg::dp_cmd_t                  cmd_i,
  output ewq_pkg::dp_status_t               stat_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [ewq_pkg::STATUS_W-1:0]      status_o,
  output logic [ewq_pkg::TASK_W-1:0]        woken_task_o,
  output logic                              last_o
);
  import ewq_pkg::*;

  localparam int unsigned EVW   = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int unsigned EXTW  = (EVW > EVENT_W) ? EVW : EVENT_W;
  localparam int unsigned HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW    = CW + 1;
  localparam int unsigned DEPTH = NUM_EVENTS * QUEUE_DEPTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TW    = (TASK_ID_BITS > TASK_W) ? TASK_ID_BITS : TASK_W;

  typedef struct packed {
    logic [HW-1:0] head;
    logic [CW-1:0] count;
  } meta_t;

  // item registers
  kind_e                   kind_q;
  logic [EVW-1:0]          ev_q;
  logic [TASK_ID_BITS-1:0] task_q;
  logic                    valid_ev_q;

  // metadata memory with per-event valid bits
  meta_t                   meta_mem [NUM_EVENTS];
  logic [NUM_EVENTS-1:0]   meta_vld_q;
  meta_t                   meta_rd_q;
  logic                    vld_rd_q;
  meta_t                   meta_cur;
  meta_t                   meta_wdata;
  logic                    meta_we;

  // waiter memory
  logic [TASK_ID_BITS-1:0] store_mem [DEPTH];
  logic [TASK_ID_BITS-1:0] rd_q;
  logic                    store_we;
  logic                    store_re;
  logic [AW-1:0]           waddr;
  logic [AW-1:0]           raddr;
  logic [AW-1:0]           ev_base;

  // drain working registers
  logic [HW-1:0]           wk_head_q;
  logic [CW-1:0]           wk_cnt_q;
  logic [HW-1:0]           head_next;

  // result register
  logic                    out_valid_q;
  logic [STATUS_W-1:0]     status_q;
  logic [TASK_W-1:0]       woken_q;
  logic                    last_q;

  logic [EXTW-1:0]         ev_ext_in;
  logic [EVW-1:0]          ev_idx_in;
  logic                    valid_ev_in;
  logic [TW-1:0]           task_ext_in;
  logic [TW-1:0]           rd_ext;
  logic [SW-1:0]           slot_sum;
  logic [HW-1:0]           slot;
  logic                    load_out;
  logic                    finish;

  assign ev_ext_in   = EXTW'(event_id_i);
  assign ev_idx_in   = ev_ext_in[EVW-1:0];
  assign valid_ev_in = (32'(event_id_i) < 32'(NUM_EVENTS));
  assign task_ext_in = TW'(task_id_i);
  assign rd_ext      = TW'(rd_q);

  assign meta_cur = vld_rd_q ? meta_rd_q : '0;

  assign slot_sum = SW'(meta_cur.head) + SW'(meta_cur.count);
  assign slot     = (slot_sum >= SW'(QUEUE_DEPTH)) ? HW'(slot_sum - SW'(QUEUE_DEPTH))
                                                    : HW'(slot_sum);
  assign head_next = (wk_head_q == HW'(QUEUE_DEPTH - 1)) ? '0 : wk_head_q + HW'(1);

  assign ev_base = AW'(ev_q) * AW'(QUEUE_DEPTH);
  assign waddr   = ev_base + AW'(slot);
  assign raddr   = cmd_i.start_wake ? ev_base + AW'(meta_cur.head) : ev_base + AW'(head_next);

  assign finish   = (kind_q == KIND_WAKE_ONE) || (wk_cnt_q == CW'(1));
  assign store_we = cmd_i.post_wait;
  assign store_re = cmd_i.start_wake || (cmd_i.emit_pop && !finish);

  always_comb begin
    meta_we    = 1'b0;
    meta_wdata = meta_cur;
    if (cmd_i.post_wait) begin
      meta_we          = 1'b1;
      meta_wdata.count = meta_cur.count + CW'(1);
    end else if (cmd_i.emit_pop && finish) begin
      meta_we = 1'b1;
      if (kind_q == KIND_WAKE_ONE) begin
        meta_wdata.head  = head_next;
        meta_wdata.count = wk_cnt_q - CW'(1);
      end else begin
        meta_wdata = '0;
      end
    end
  end

  always_comb begin
    stat_o.out_free = !out_valid_q || !out_stall_i;
    stat_o.is_wait  = (kind_q == KIND_WAIT);
    stat_o.room     = valid_ev_q && (meta_cur.count < CW'(QUEUE_DEPTH));
    stat_o.none     = (kind_q == KIND_RSVD) || !valid_ev_q || (meta_cur.count == '0);
    stat_o.finish   = finish;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q     <= kind_e'(kind_i);
      ev_q       <= ev_idx_in;
      task_q     <= task_ext_in[TASK_ID_BITS-1:0];
      valid_ev_q <= valid_ev_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      meta_rd_q <= meta_mem[ev_idx_in];
    end
    if (meta_we) begin
      meta_mem[ev_q] <= meta_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_vld_q <= '0;
      vld_rd_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        vld_rd_q <= valid_ev_in && meta_vld_q[ev_idx_in];
      end
      if (meta_we) begin
        meta_vld_q[ev_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[waddr] <= task_q;
    end
    if (store_re) begin
      rd_q <= store_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_wake) begin
      wk_head_q <= meta_cur.head;
      wk_cnt_q  <= meta_cur.count;
    end else if (cmd_i.emit_pop) begin
      wk_head_q <= head_next;
      wk_cnt_q  <= wk_cnt_q - CW'(1);
    end
  end

  assign load_out = cmd_i.post_wait || cmd_i.post_full || cmd_i.post_none || cmd_i.emit_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (cmd_i.emit_pop) begin
        status_q <= ST_WOKEN;
        woken_q  <= rd_ext[TASK_W-1:0];
        last_q   <= finish;
      end else begin
        status_q <= cmd_i.post_wait ? ST_SUSPENDED :
                    cmd_i.post_full ? ST_FULL : ST_NONE;
        woken_q  <= '0;
        last_q   <= 1'b1;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign woken_task_o = woken_q;
  assign last_o       = last_q;

endmodule
`default_nettype wire
